// ===== hw/rtl/pli_pkg.sv =====
// Shared types and constants of the piecewise Lagrange interpolator.
// No dependencies; used by the top level through scoped names.
package pli_pkg;

    localparam int DEF_NODE_DEPTH = 16;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_NODES  = 1'b1;

    localparam logic [1:0] DEGREE_RESET = 2'd1;
    localparam logic [4:0] NODES_RESET  = 5'd16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WADR,
        S_WCHK,
        S_X0,
        S_XD,
        S_SPAN,
        S_DIV,
        S_PSI,
        S_SQ,
        S_P2,
        S_CU,
        S_P3,
        S_WGT,
        S_YRD,
        S_YMUL,
        S_ACC,
        S_SAT
    } t_state;

endpackage

// ===== hw/rtl/piecewise_lagrange_interpolator.sv =====
// Piecewise Lagrange interpolator top level: node tables, segment walk,
// psi divider and a shared multiplier. Uses pli_pkg and pli_ram.
//
//  channel | direction | handshake                   | beat
//  in      | in        | i_in_valid / o_in_stall     | load or query item
//  out     | out       | o_out_valid / i_out_stall   | one result per query
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | register index and data
//
// A query walks the segments, skipping the last comparison when the walk stops at
// the last element, and skips the divide when psi is out of range before dividing.
// The restoring divider (one quotient bit a cycle) and the single multiplier
// carry its arithmetic; the input stalls until the query has finished.
// Reset is synchronous, active low; tables are not cleared.
// A finished result waits in the output register while the next item enters;
// a query that ends while that register is stalled holds until it frees.
module piecewise_lagrange_interpolator #(
    parameter int NODE_DEPTH = pli_pkg::DEF_NODE_DEPTH,
    parameter int FRAC_BITS  = pli_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [3:0]         i_node_slot,
    input  logic signed [31:0] i_node_abscissa,
    input  logic signed [31:0] i_node_ordinate,
    input  logic signed [31:0] i_query_point,
    input  logic               i_restart_walk,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_interpolated,
    output logic [3:0]         o_segment_used,
    output logic               o_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data
);

    localparam int AWP = $clog2(NODE_DEPTH);
    localparam int CW  = AWP + 3;
    localparam int WW  = FRAC_BITS + 10;
    localparam int PRW = 32 + WW;
    localparam int AW  = PRW - FRAC_BITS + 1;
    localparam int QB  = FRAC_BITS + 3;
    localparam int DW  = FRAC_BITS + 34;
    localparam int RW  = 34;
    localparam int PSW = FRAC_BITS + 3;
    localparam int QCW = $clog2(QB + 1);

    localparam logic [QB-1:0]         QU_ONE  = QB'(1) << FRAC_BITS;
    localparam logic [QB-1:0]         QU_TWO  = QB'(1) << (FRAC_BITS + 1);
    localparam logic signed [WW-1:0]  W_TWO   = WW'(1) << (FRAC_BITS + 1);
    localparam logic signed [PRW-1:0] HALF_P  = PRW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PRW-1:0] HALF_T  = PRW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0]  SAT_MAX = AW'(33'sh0_7FFF_FFFF);
    localparam logic signed [AW-1:0]  SAT_MIN = -AW'(33'sh0_8000_0000);

    pli_pkg::t_state r_state, n_state;

    logic [1:0]        r_degree;
    logic [4:0]        r_nodes;
    logic [AWP-1:0]    r_ptr, n_ptr;
    logic [1:0]        r_d;
    logic [CW-1:0]     r_n;
    logic signed [31:0] r_q;
    logic signed [31:0] r_x0;
    logic [32:0]       r_ud;
    logic              r_neg;
    logic [RW-1:0]     r_rem;
    logic [QB-1:0]     r_dq;
    logic [QCW-1:0]    r_cnt;
    logic signed [PSW-1:0] r_psi;
    logic signed [WW-1:0]  r_p2, r_p3;
    logic signed [WW-1:0]  r_w [4];
    logic [1:0]        r_k;
    logic signed [AW-1:0]  r_acc;
    logic signed [PRW-1:0] r_prod;
    logic              r_fault;
    logic              r_ov;
    logic signed [31:0] r_o_val;
    logic [3:0]        r_o_seg;
    logic              r_o_fault;

    logic              in_acc, load_we, out_load;
    logic [AWP-1:0]    a_raddr, o_raddr;
    logic [31:0]       a_rdata, o_rdata;
    logic [1:0]        q_d;
    logic [CW-1:0]     q_n;
    logic [AWP-1:0]    q_p;
    logic signed [32:0] span, num;
    logic [32:0]       ud, mag;
    logic [DW-1:0]     dvd;
    logic [RW-1:0]     dv_t;
    logic signed [31:0]   mul_a;
    logic signed [WW-1:0] mul_b;
    logic [QB-1:0]     qu;
    logic signed [WW-1:0] psi_w;
    logic signed [AW-1:0] acc_sat;
    logic              sat_hit;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != pli_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign load_we     = in_acc && (i_opcode == pli_pkg::OP_LOAD)
                         && (CW'(i_node_slot) < CW'(NODE_DEPTH));

    pli_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_abscissa (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AWP'(i_node_slot)),
        .i_wdata (i_node_abscissa),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    pli_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_ordinate (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AWP'(i_node_slot)),
        .i_wdata (i_node_ordinate),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    // Query setup: effective degree, node count and starting pointer.
    always_comb begin
        q_d = (r_degree == 2'd0) ? 2'd1 : r_degree;
        q_n = (CW'(r_nodes) > CW'(NODE_DEPTH)) ? CW'(NODE_DEPTH) : CW'(r_nodes);
        if (q_n < CW'(q_d) + CW'(1)) begin
            q_n = CW'(q_d) + CW'(1);
        end
        q_p = i_restart_walk ? '0 : r_ptr;
        if (CW'(q_p) + CW'(q_d) > q_n - CW'(1)) begin
            q_p = '0;
        end
    end

    // Span, numerator and divider setup.
    always_comb begin
        span = {a_rdata[31], a_rdata} - {r_x0[31], r_x0};
        num  = {r_q[31], r_q} - {r_x0[31], r_x0};
        ud   = span[32] ? 33'(-span) : 33'(span);
        mag  = num[32] ? 33'(-num) : 33'(num);
        dvd  = (DW'(mag) << FRAC_BITS) + DW'(ud >> 1);
        dv_t = {r_rem[RW-2:0], r_dq[QB-1]};
        qu   = (r_dq > QU_TWO) ? QU_TWO : r_dq;
        psi_w = WW'(r_psi);
    end

    // Shared multiplier operands.
    always_comb begin
        case (r_state)
            pli_pkg::S_SQ: begin
                mul_a = 32'(r_psi);
                mul_b = psi_w;
            end
            pli_pkg::S_CU: begin
                mul_a = 32'(r_p2);
                mul_b = psi_w;
            end
            default: begin
                mul_a = o_rdata;
                mul_b = r_w[r_k];
            end
        endcase
    end

    always_comb begin
        acc_sat = r_acc;
        sat_hit = 1'b0;
        if (r_acc > SAT_MAX) begin
            acc_sat = SAT_MAX;
            sat_hit = 1'b1;
        end else if (r_acc < SAT_MIN) begin
            acc_sat = SAT_MIN;
            sat_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, pointer and RAM read addresses.
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        out_load = 1'b0;
        a_raddr  = r_ptr;
        o_raddr  = AWP'(r_ptr + AWP'(r_k));
        case (r_state)
            pli_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == pli_pkg::OP_LOAD) begin
                        n_ptr = '0;
                    end else begin
                        n_ptr   = q_p;
                        n_state = pli_pkg::S_WADR;
                    end
                end
            end
            pli_pkg::S_WADR: begin
                a_raddr = AWP'(r_ptr + AWP'(r_d));
                if (CW'(r_ptr) + (CW'(r_d) << 1) <= r_n - CW'(1)) begin
                    n_state = pli_pkg::S_WCHK;
                end else begin
                    n_state = pli_pkg::S_X0;
                end
            end
            pli_pkg::S_WCHK: begin
                if (r_q > $signed(a_rdata)) begin
                    n_ptr   = AWP'(r_ptr + AWP'(r_d));
                    n_state = pli_pkg::S_WADR;
                end else begin
                    n_state = pli_pkg::S_X0;
                end
            end
            pli_pkg::S_X0: n_state = pli_pkg::S_XD;
            pli_pkg::S_XD: begin
                a_raddr = AWP'(r_ptr + AWP'(r_d));
                n_state = pli_pkg::S_SPAN;
            end
            pli_pkg::S_SPAN: begin
                if (span == '0) begin
                    n_state = pli_pkg::S_SQ;
                end else if ((dvd >> QB) >= DW'(ud)) begin
                    n_state = pli_pkg::S_PSI;
                end else begin
                    n_state = pli_pkg::S_DIV;
                end
            end
            pli_pkg::S_DIV: begin
                if (r_cnt == QCW'(1)) begin
                    n_state = pli_pkg::S_PSI;
                end
            end
            pli_pkg::S_PSI: n_state = pli_pkg::S_SQ;
            pli_pkg::S_SQ:  n_state = pli_pkg::S_P2;
            pli_pkg::S_P2:  n_state = pli_pkg::S_CU;
            pli_pkg::S_CU:  n_state = pli_pkg::S_P3;
            pli_pkg::S_P3:  n_state = pli_pkg::S_WGT;
            pli_pkg::S_WGT: n_state = pli_pkg::S_YRD;
            pli_pkg::S_YRD: n_state = pli_pkg::S_YMUL;
            pli_pkg::S_YMUL: n_state = pli_pkg::S_ACC;
            pli_pkg::S_ACC: begin
                if (r_k == r_d) begin
                    n_state = pli_pkg::S_SAT;
                end else begin
                    n_state = pli_pkg::S_YRD;
                end
            end
            pli_pkg::S_SAT: begin
                // hold until the output register is free
                if (!r_ov || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = pli_pkg::S_IDLE;
                end
            end
            default: n_state = pli_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= pli_pkg::DEGREE_RESET;
            r_nodes  <= pli_pkg::NODES_RESET;
            r_ptr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pli_pkg::CFG_DEGREE: r_degree <= i_cfg_data[1:0];
                    pli_pkg::CFG_NODES:  r_nodes  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= PRW'(mul_a * mul_b);
        case (r_state)
            pli_pkg::S_IDLE: begin
                r_d     <= q_d;
                r_n     <= q_n;
                r_q     <= i_query_point;
                r_fault <= 1'b0;
            end
            pli_pkg::S_XD: r_x0 <= a_rdata;
            pli_pkg::S_SPAN: begin
                r_ud  <= ud;
                r_neg <= num[32] != span[32];
                r_rem <= RW'(dvd >> QB);
                r_dq  <= dvd[QB-1:0];
                r_cnt <= QCW'(QB);
                if (span == '0) begin
                    r_psi   <= '0;
                    r_fault <= 1'b1;
                end else if ((dvd >> QB) >= DW'(ud)) begin
                    r_dq <= QU_TWO;
                end
            end
            pli_pkg::S_DIV: begin
                if (dv_t >= RW'(r_ud)) begin
                    r_rem <= dv_t - RW'(r_ud);
                    r_dq  <= {r_dq[QB-2:0], 1'b1};
                end else begin
                    r_rem <= dv_t;
                    r_dq  <= {r_dq[QB-2:0], 1'b0};
                end
                r_cnt <= r_cnt - QCW'(1);
            end
            pli_pkg::S_PSI: begin
                if (r_neg && qu > QU_ONE) begin
                    r_psi   <= -PSW'(QU_ONE);
                    r_fault <= 1'b1;
                end else if (r_neg) begin
                    r_psi <= -PSW'(qu);
                end else begin
                    r_psi <= PSW'(qu);
                end
            end
            pli_pkg::S_P2: r_p2 <= WW'((r_prod + HALF_P) >>> FRAC_BITS);
            pli_pkg::S_P3: r_p3 <= WW'((r_prod + HALF_P) >>> FRAC_BITS);
            pli_pkg::S_WGT: begin
                r_k   <= '0;
                r_acc <= '0;
                case (r_d)
                    2'd2: begin
                        r_w[0] <= WW'(W_TWO - 6 * psi_w + 4 * r_p2);
                        r_w[1] <= WW'(8 * psi_w - 8 * r_p2);
                        r_w[2] <= WW'(-2 * psi_w + 4 * r_p2);
                        r_w[3] <= '0;
                    end
                    2'd3: begin
                        r_w[0] <= WW'(W_TWO - 11 * psi_w + 18 * r_p2 - 9 * r_p3);
                        r_w[1] <= WW'(18 * psi_w - 45 * r_p2 + 27 * r_p3);
                        r_w[2] <= WW'(-9 * psi_w + 36 * r_p2 - 27 * r_p3);
                        r_w[3] <= WW'(2 * psi_w - 9 * r_p2 + 9 * r_p3);
                    end
                    default: begin
                        r_w[0] <= WW'(W_TWO - 2 * psi_w);
                        r_w[1] <= WW'(2 * psi_w);
                        r_w[2] <= '0;
                        r_w[3] <= '0;
                    end
                endcase
            end
            pli_pkg::S_ACC: begin
                r_acc <= r_acc + AW'((r_prod + HALF_T) >>> (FRAC_BITS + 1));
                r_k   <= r_k + 2'd1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_val   <= 32'(acc_sat);
            r_o_seg   <= 4'(r_ptr);
            r_o_fault <= r_fault || sat_hit;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_interpolated = r_o_val;
    assign o_segment_used = r_o_seg;
    assign o_fault        = r_o_fault;

    a_load_clears_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == pli_pkg::OP_LOAD) |=> r_ptr == '0)
        else $error("segment pointer not cleared by load");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pli_pkg::S_DIV) |-> r_ud != '0)
        else $error("divider running on zero span");

    a_elem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pli_pkg::S_X0) |-> CW'(r_ptr) + CW'(r_d) <= r_n - CW'(1))
        else $error("element ends beyond nodes in use");

    a_degree_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pli_pkg::S_IDLE) |-> r_d != 2'd0)
        else $error("zero degree in query");

endmodule

// ===== hw/rtl/pli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
